// ===== rtl/core/pfa_pkg.sv =====
// Shared types, constants and helper functions of the page frame allocator.
package pfa_pkg;

	localparam int NUM_PAGES = 128;
	localparam longint PAGE_BYTES = 64'd2097152;
	localparam int IDX_W = $clog2(NUM_PAGES);
	localparam int PAGE_W = 8;
	localparam int ADDR_W = 28;
	localparam int PROD_W = PAGE_W + ADDR_W;
	localparam logic [PAGE_W-1:0] NONE_PAGE = PAGE_W'(NUM_PAGES);

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE = 2'd1,
		ACT_READ = 2'd2,
		ACT_REINIT = 2'd3
	} pfa_action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NONE = 2'd1,
		ST_SHORT = 2'd2
	} pfa_status_t;

	typedef enum logic [1:0] {
		RS_NONE = 2'd0,
		RS_HEAD = 2'd1,
		RS_LINK = 2'd2
	} pfa_res_sel_t;

	typedef struct packed {
		logic [1:0] action;
		logic [PAGE_W-1:0] page_count;
		logic [PAGE_W-1:0] page_index;
	} pfa_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [PAGE_W-1:0] result_page;
		logic [ADDR_W-1:0] phys_addr;
		logic [PAGE_W-1:0] free_pages;
	} pfa_out_t;

	typedef struct packed {
		logic load;
		logic a_start;
		logic a_step;
		logic a_end;
		logic f_start;
		logic f_step;
		logic f_end;
		logic rd_idx;
		logic reinit;
		logic fin;
		pfa_status_t fin_status;
		pfa_res_sel_t fin_sel;
		logic emit;
	} pfa_cmd_t;

	typedef struct packed {
		pfa_action_t action;
		logic cnt_zero;
		logic idx_none;
		logic ptr_none;
		logic cnt_last;
		logic link_more;
		logic out_busy;
	} pfa_sts_t;

	function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] page);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(page) * PROD_W'(PAGE_BYTES);
		if (page >= NONE_PAGE)
			return '0;
		return prod[ADDR_W-1:0];
	endfunction

	function automatic logic [PAGE_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
		if (idx == '0)
			return NONE_PAGE;
		return PAGE_W'(idx) - PAGE_W'(1);
	endfunction

endpackage

// ===== rtl/core/page_frame_free_list_allocator_top.sv =====
// Page frame allocator that keeps its free pages as a singly linked list in a link table.
// Each request word carries an action (alloc, free chain, read next link, reinit) and
// returns exactly one response word. The link table is read one entry per cycle, so the
// time per word of alloc and free chain follows the length of the list walk. Reinit clears
// the table at once through per-entry valid bits, so no clearing pass is needed after
// reset. A finished response sits in an output register, and the next request is taken
// while it waits.
module page_frame_free_list_allocator_top import pfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  pfa_in_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output pfa_out_t rsp
);

	pfa_cmd_t cmd;
	pfa_sts_t sts;

	pfa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts(sts),
		.cmd(cmd)
	);

	pfa_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

endmodule

// ===== rtl/core/pfa_dp.sv =====
// Datapath of the page frame allocator: link table, list registers and result word.
module pfa_dp import pfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  pfa_in_t req,
	input  pfa_cmd_t cmd,
	output pfa_sts_t sts,
	output pfa_out_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);

	logic [PAGE_W-1:0] mem [NUM_PAGES];
	logic [NUM_PAGES-1:0] vld_q;
	logic [PAGE_W-1:0] rd_data_q;
	logic rd_vld_q;
	logic [IDX_W-1:0] rd_addr_q;

	pfa_in_t in_q;
	logic [PAGE_W-1:0] head_q;
	logic [PAGE_W-1:0] total_q;
	logic [PAGE_W-1:0] ptr_q;
	logic [IDX_W-1:0] last_q;
	logic [PAGE_W-1:0] cnt_q;
	logic use_mem_q;
	pfa_status_t res_status_q;
	logic [PAGE_W-1:0] res_page_q;
	pfa_out_t rsp_q;
	logic rsp_valid_q;

	logic [PAGE_W-1:0] rd_eff;
	logic [PAGE_W-1:0] ptr;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [PAGE_W-1:0] wr_data;
	logic [PAGE_W:0] free_sum;
	logic [PAGE_W-1:0] total_alloc;
	logic [PAGE_W-1:0] total_free;

	assign rd_eff = rd_vld_q ? rd_data_q : reset_link(rd_addr_q);
	assign ptr = use_mem_q ? rd_eff : ptr_q;
	assign rd_en = cmd.a_step | cmd.f_start | cmd.f_step | cmd.rd_idx;
	assign wr_en = cmd.a_end | cmd.f_end;
	assign wr_data = cmd.f_end ? head_q : NONE_PAGE;

	always_comb begin
		priority if (cmd.a_step) begin
			rd_addr = ptr[IDX_W-1:0];
		end else if (cmd.f_step) begin
			rd_addr = rd_eff[IDX_W-1:0];
		end else begin
			rd_addr = in_q.page_index[IDX_W-1:0];
		end
	end

	assign free_sum = {1'b0, total_q} + {1'b0, cnt_q};
	assign total_free = (free_sum > (PAGE_W+1)'(NUM_PAGES)) ? NONE_PAGE : free_sum[PAGE_W-1:0];
	assign total_alloc = (total_q > in_q.page_count) ? total_q - in_q.page_count : '0;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[last_q] <= wr_data;
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= req;
		if (cmd.a_start) begin
			ptr_q <= head_q;
			cnt_q <= '0;
		end
		if (cmd.a_step) begin
			last_q <= ptr[IDX_W-1:0];
			cnt_q <= cnt_q + PAGE_W'(1);
		end
		if (cmd.f_start) begin
			last_q <= in_q.page_index[IDX_W-1:0];
			cnt_q <= PAGE_W'(1);
		end
		if (cmd.f_step) begin
			last_q <= rd_eff[IDX_W-1:0];
			cnt_q <= cnt_q + PAGE_W'(1);
		end
		if (cmd.fin) begin
			res_status_q <= cmd.fin_status;
			unique case (cmd.fin_sel)
				RS_HEAD: res_page_q <= head_q;
				RS_LINK: res_page_q <= rd_eff;
				default: res_page_q <= NONE_PAGE;
			endcase
		end
		if (cmd.emit) begin
			rsp_q.status <= res_status_q;
			rsp_q.result_page <= res_page_q;
			rsp_q.phys_addr <= page_addr(res_page_q);
			rsp_q.free_pages <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			head_q <= PAGE_W'(NUM_PAGES - 1);
			total_q <= PAGE_W'(NUM_PAGES);
			use_mem_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.a_start)
				use_mem_q <= 1'b0;
			if (cmd.a_step)
				use_mem_q <= 1'b1;
			if (cmd.reinit) begin
				vld_q <= '0;
				head_q <= PAGE_W'(NUM_PAGES - 1);
				total_q <= PAGE_W'(NUM_PAGES);
			end
			if (wr_en)
				vld_q[last_q] <= 1'b1;
			if (cmd.a_end) begin
				head_q <= ptr;
				total_q <= total_alloc;
			end
			if (cmd.f_end) begin
				head_q <= in_q.page_index;
				total_q <= total_free;
			end
			if (cmd.emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign sts.action = pfa_action_t'(in_q.action);
	assign sts.cnt_zero = (in_q.page_count == '0);
	assign sts.idx_none = (in_q.page_index >= NONE_PAGE);
	assign sts.ptr_none = (ptr >= NONE_PAGE);
	assign sts.cnt_last = (cnt_q == in_q.page_count - PAGE_W'(1));
	assign sts.link_more = (rd_eff < NONE_PAGE) && (cnt_q < NONE_PAGE);
	assign sts.out_busy = rsp_valid_q && !rsp_ready;

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/core/pfa_ctrl.sv =====
// Controller state machine of the page frame allocator.
module pfa_ctrl import pfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  pfa_sts_t sts,
	output pfa_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_A_WALK,
		S_A_END,
		S_F_WALK,
		S_R_WAIT,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.action)
					ACT_ALLOC: begin
						if (sts.cnt_zero) begin
							cmd.fin = 1'b1;
							cmd.fin_status = ST_NONE;
							state_d = S_RESP;
						end else begin
							cmd.a_start = 1'b1;
							state_d = S_A_WALK;
						end
					end
					ACT_FREE: begin
						if (sts.idx_none) begin
							cmd.fin = 1'b1;
							cmd.fin_status = ST_NONE;
							state_d = S_RESP;
						end else begin
							cmd.f_start = 1'b1;
							state_d = S_F_WALK;
						end
					end
					ACT_READ: begin
						if (sts.idx_none) begin
							cmd.fin = 1'b1;
							cmd.fin_status = ST_NONE;
							state_d = S_RESP;
						end else begin
							cmd.rd_idx = 1'b1;
							state_d = S_R_WAIT;
						end
					end
					ACT_REINIT: begin
						cmd.reinit = 1'b1;
						cmd.fin = 1'b1;
						state_d = S_RESP;
					end
				endcase
			end
			S_A_WALK: begin
				if (sts.ptr_none) begin
					cmd.fin = 1'b1;
					cmd.fin_status = ST_SHORT;
					state_d = S_RESP;
				end else begin
					cmd.a_step = 1'b1;
					if (sts.cnt_last)
						state_d = S_A_END;
				end
			end
			S_A_END: begin
				cmd.a_end = 1'b1;
				cmd.fin = 1'b1;
				cmd.fin_sel = RS_HEAD;
				state_d = S_RESP;
			end
			S_F_WALK: begin
				if (sts.link_more) begin
					cmd.f_step = 1'b1;
				end else begin
					cmd.f_end = 1'b1;
					cmd.fin = 1'b1;
					state_d = S_RESP;
				end
			end
			S_R_WAIT: begin
				cmd.fin = 1'b1;
				cmd.fin_sel = RS_LINK;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

endmodule

// ===== rtl/core/pfa_chk.sv =====
// Port-level assertions of the page frame allocator and their bind to the top level.
module pfa_chk import pfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input pfa_out_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous word in work");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.free_pages <= NONE_PAGE)
		else $error("free page count above page total");

	a_fail_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.result_page == NONE_PAGE && rsp.phys_addr == '0)
		else $error("failed action returned a page");

	a_none_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_page == NONE_PAGE |-> rsp.phys_addr == '0)
		else $error("address given for no page");

endmodule

bind page_frame_free_list_allocator_top pfa_chk u_pfa_chk (.*);

// ===== tb/tb_page_frame_free_list_allocator_top.sv =====
// Testbench for the page frame free list allocator: directed, random, hold-off and streaming runs.
module tb_page_frame_free_list_allocator_top;
	import pfa_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	pfa_in_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	pfa_out_t rsp;

	logic [PAGE_W-1:0] link_tab [NUM_PAGES];
	logic [PAGE_W-1:0] list_head;
	int unsigned list_free;

	pfa_out_t rsp_expected [$];
	logic [PAGE_W-1:0] held_heads [$];
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit src_idle = 1'b1;
	logic sink_idle = 1'b1;
	int unsigned hold_req = 0;
	int unsigned hold_ack = 0;
	int unsigned stall_left = 0;

	page_frame_free_list_allocator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_page_frame_free_list_allocator_top failed");
			$finish;
		end
	end

	function automatic void frame_list_rebuild();
		link_tab[0] = NONE_PAGE;
		for (int i = 1; i < NUM_PAGES; i++)
			link_tab[i] = PAGE_W'(i - 1);
		list_head = PAGE_W'(NUM_PAGES - 1);
		list_free = NUM_PAGES;
	endfunction

	function automatic pfa_out_t frame_list_step(input pfa_in_t w);
		pfa_out_t o;
		logic [PAGE_W-1:0] cur;
		logic [PAGE_W-1:0] last;
		logic [PAGE_W-1:0] tail;
		logic [PAGE_W-1:0] page;
		int unsigned len;
		bit short_list;
		o.status = ST_OK;
		page = NONE_PAGE;
		case (w.action)
			ACT_ALLOC: begin
				if (w.page_count == '0) begin
					o.status = ST_NONE;
				end else begin
					cur = list_head;
					last = NONE_PAGE;
					short_list = 1'b0;
					for (int n = 0; n < w.page_count; n++) begin
						if (cur >= NONE_PAGE) begin
							short_list = 1'b1;
							break;
						end
						last = cur;
						cur = link_tab[cur[IDX_W-1:0]];
					end
					if (short_list) begin
						o.status = ST_SHORT;
					end else begin
						page = list_head;
						list_head = cur;
						link_tab[last[IDX_W-1:0]] = NONE_PAGE;
						list_free = (list_free > w.page_count) ? list_free - w.page_count : 0;
					end
				end
			end
			ACT_FREE: begin
				if (w.page_index >= NONE_PAGE) begin
					o.status = ST_NONE;
				end else begin
					tail = w.page_index;
					len = 1;
					while (len < NUM_PAGES && link_tab[tail[IDX_W-1:0]] < NONE_PAGE) begin
						tail = link_tab[tail[IDX_W-1:0]];
						len++;
					end
					link_tab[tail[IDX_W-1:0]] = list_head;
					list_head = w.page_index;
					list_free = (list_free + len > NUM_PAGES) ? NUM_PAGES : list_free + len;
				end
			end
			ACT_READ: begin
				if (w.page_index >= NONE_PAGE)
					o.status = ST_NONE;
				else
					page = link_tab[w.page_index[IDX_W-1:0]];
			end
			default: begin
				frame_list_rebuild();
			end
		endcase
		o.result_page = page;
		o.phys_addr = (page >= NONE_PAGE) ? '0 : ADDR_W'(longint'(page) * PAGE_BYTES);
		o.free_pages = PAGE_W'(list_free);
		return o;
	endfunction

	function automatic pfa_in_t mk_word(input pfa_action_t act, input int unsigned cnt,
		input int unsigned idx);
		pfa_in_t w;
		w.action = act;
		w.page_count = PAGE_W'(cnt);
		w.page_index = PAGE_W'(idx);
		return w;
	endfunction

	task automatic send_word(input pfa_in_t w, output pfa_out_t exp_rsp);
		int unsigned gap;
		if (src_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		exp_rsp = frame_list_step(w);
		rsp_expected.push_back(exp_rsp);
	endtask

	always @(posedge clk) begin
		pfa_out_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_expected.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected word: status=%0d page=%0d addr=%h free=%0d",
						rsp.status, rsp.result_page, rsp.phys_addr, rsp.free_pages);
			end else begin
				exp_rsp = rsp_expected.pop_front();
				if (rsp.status !== exp_rsp.status || rsp.result_page !== exp_rsp.result_page ||
					rsp.phys_addr !== exp_rsp.phys_addr ||
					rsp.free_pages !== exp_rsp.free_pages) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: exp status=%0d page=%0d addr=%h free=%0d, got status=%0d page=%0d addr=%h free=%0d",
							exp_rsp.status, exp_rsp.result_page, exp_rsp.phys_addr,
							exp_rsp.free_pages, rsp.status, rsp.result_page, rsp.phys_addr,
							rsp.free_pages);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			stall_left <= HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (sink_idle && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 11);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic run_list_traffic(input int unsigned n_words);
		pfa_out_t r;
		int unsigned p;
		int unsigned cnt;
		int unsigned pick;
		for (int k = 0; k < n_words; k++) begin
			p = $urandom_range(0, 99);
			if (p >= 44 && p < 80 && held_heads.size() != 0) begin
				pick = $urandom_range(0, held_heads.size() - 1);
				send_word(mk_word(ACT_FREE, $urandom_range(0, NUM_PAGES), held_heads[pick]), r);
				held_heads.delete(pick);
			end else if (p < 80) begin
				case ($urandom_range(0, 19))
					0: cnt = 0;
					1: cnt = $urandom_range(1, NUM_PAGES);
					default: cnt = $urandom_range(1, 8);
				endcase
				send_word(mk_word(ACT_ALLOC, cnt, $urandom_range(0, NUM_PAGES)), r);
				if (r.status == ST_OK)
					held_heads.push_back(r.result_page);
			end else if (p < 92) begin
				cnt = ($urandom_range(0, 19) == 0) ? NUM_PAGES : $urandom_range(0, NUM_PAGES - 1);
				send_word(mk_word(ACT_READ, $urandom_range(0, NUM_PAGES), cnt), r);
			end else if (p < 95) begin
				send_word(mk_word(ACT_REINIT, $urandom_range(0, NUM_PAGES),
					$urandom_range(0, NUM_PAGES)), r);
				held_heads.delete();
			end else begin
				send_word(mk_word(ACT_FREE, $urandom_range(0, NUM_PAGES),
					$urandom_range(0, NUM_PAGES)), r);
			end
		end
	endtask

	task automatic test_directed();
		pfa_out_t r;
		logic [PAGE_W-1:0] one_head;
		logic [PAGE_W-1:0] all_head;
		send_word(mk_word(ACT_READ, 0, 0), r);
		send_word(mk_word(ACT_READ, 0, NUM_PAGES - 1), r);
		send_word(mk_word(ACT_READ, NUM_PAGES, NUM_PAGES), r);
		send_word(mk_word(ACT_ALLOC, 0, 0), r);
		send_word(mk_word(ACT_ALLOC, 1, NUM_PAGES), r);
		one_head = r.result_page;
		send_word(mk_word(ACT_ALLOC, NUM_PAGES, 0), r);
		send_word(mk_word(ACT_ALLOC, NUM_PAGES - 1, 0), r);
		all_head = r.result_page;
		send_word(mk_word(ACT_ALLOC, 1, 0), r);
		send_word(mk_word(ACT_READ, 0, 0), r);
		send_word(mk_word(ACT_FREE, 0, NUM_PAGES), r);
		send_word(mk_word(ACT_FREE, 0, one_head), r);
		send_word(mk_word(ACT_FREE, 0, all_head), r);
		send_word(mk_word(ACT_ALLOC, NUM_PAGES, 0), r);
		all_head = r.result_page;
		send_word(mk_word(ACT_READ, 0, all_head), r);
		send_word(mk_word(ACT_FREE, 0, all_head), r);
		send_word(mk_word(ACT_FREE, 0, NUM_PAGES - 1), r);
		send_word(mk_word(ACT_FREE, 0, 5), r);
		send_word(mk_word(ACT_ALLOC, 3, 0), r);
		send_word(mk_word(ACT_READ, 0, 85), r);
		send_word(mk_word(ACT_REINIT, NUM_PAGES, NUM_PAGES), r);
		send_word(mk_word(ACT_ALLOC, 3, 0), r);
		send_word(mk_word(ACT_READ, 0, r.result_page), r);
		send_word(mk_word(ACT_REINIT, 0, 0), r);
	endtask

	task automatic test_random_gaps();
		run_list_traffic(700);
	endtask

	task automatic test_output_hold();
		hold_req <= hold_req + 1;
		run_list_traffic(40);
	endtask

	task automatic test_streaming();
		src_idle = 1'b0;
		sink_idle <= 1'b0;
		run_list_traffic(320);
	endtask

	initial begin
		frame_list_rebuild();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_gaps();
		test_output_hold();
		test_streaming();
		req_valid <= 1'b0;
		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_page_frame_free_list_allocator_top passed");
		else
			$display("tb_page_frame_free_list_allocator_top failed");
		$finish;
	end

endmodule

// ===== page_frame_free_list_allocator_top.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_dp.sv
rtl/core/pfa_ctrl.sv
rtl/core/page_frame_free_list_allocator_top.sv
rtl/core/pfa_chk.sv
tb/tb_page_frame_free_list_allocator_top.sv
